/* design/slle_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted linked list engine package
// Shared types and codes for the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package slle_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 64;

  // Input action, carried on the slave tuser.
  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_WALK   = 1'b1
  } action_e;

  // Result kind, carried on the master tuser.
  typedef enum logic [1:0] {
    RES_INSERTED = 2'd0,
    RES_FULL     = 2'd1,
    RES_ENTRY    = 2'd2,
    RES_EMPTY    = 2'd3
  } res_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        start_ins;   // capture item, begin the search at the head
    logic        start_walk;  // begin a walk at the head
    logic        scan_step;   // move the search one node on
    logic        link_node;   // write the new node
    logic        fix_links;   // patch the neighbours and the head, count the node
    logic        walk_step;   // move the walk one node on
    logic        load_out;    // load the output register
    res_status_e out_kind;    // kind of result to load
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_walk;     // the offered item asks for a walk
    logic pool_full;   // no free node within the limit in force
    logic list_empty;  // nothing to walk
    logic scan_more;   // the node under the search key is still smaller
    logic walk_fin;    // the entry just read is the final one of the walk
    logic out_free;    // the output register can take a result this cycle
  } dp_status_t;

endpackage

/* design/slle_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted linked list engine controller
// One-hot state machine that sequences inserts, walks and result hand-off.
// ----------------------------------------------------------------------------
module slle_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  slle_pkg::dp_status_t  status_i,
  output slle_pkg::ctrl_cmd_t   cmd_o
);
  import slle_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_LINK  = 8'b0000_0100,
    S_FIX   = 8'b0000_1000,
    S_DONE  = 8'b0001_0000,
    S_FULL  = 8'b0010_0000,
    S_EMPTY = 8'b0100_0000,
    S_WALK  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_kind = RES_INSERTED;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (status_i.is_walk) begin
            if (status_i.list_empty) begin
              state_d = S_EMPTY;
            end else begin
              cmd_o.start_walk = 1'b1;
              state_d          = S_WALK;
            end
          end else begin
            if (status_i.pool_full) begin
              state_d = S_FULL;
            end else begin
              cmd_o.start_ins = 1'b1;
              state_d         = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (status_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        cmd_o.link_node = 1'b1;
        state_d         = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix_links = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = RES_INSERTED;
          state_d        = S_IDLE;
        end
      end
      S_FULL: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = RES_FULL;
          state_d        = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = RES_EMPTY;
          state_d        = S_IDLE;
        end
      end
      S_WALK: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = RES_ENTRY;
          if (status_i.walk_fin) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.walk_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/slle_dp.sv */
// ----------------------------------------------------------------------------
// Sorted linked list engine datapath
// Node memories, search and walk pointers, list counters and output register.
// ----------------------------------------------------------------------------
module slle_dp #(
  parameter int unsigned NODES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [$clog2(NODES):0]              cfg_wdata_i,
  input  logic [slle_pkg::KEY_W+slle_pkg::VAL_W-1:0] in_data_i,
  input  logic                                in_action_i,
  input  slle_pkg::ctrl_cmd_t                 cmd_i,
  output slle_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          out_status_o,
  output logic [$clog2(NODES)-1:0]            out_node_o,
  output logic [$clog2(NODES):0]              out_prev_o,
  output logic [$clog2(NODES):0]              out_next_o,
  output logic [slle_pkg::KEY_W-1:0]          out_key_o,
  output logic [slle_pkg::VAL_W-1:0]          out_value_o,
  output logic                                out_last_o
);
  import slle_pkg::*;

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned LW = IW + 1;
  localparam logic [LW-1:0] NONE = LW'(NODES);

  // Node memories, undefined until an insert writes them.
  logic [KEY_W-1:0] key_mem  [NODES];
  logic [VAL_W-1:0] val_mem  [NODES];
  logic [LW-1:0]    prev_mem [NODES];
  logic [LW-1:0]    next_mem [NODES];

  logic [LW-1:0]    cap_q, head_q, used_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [LW-1:0]    pv_q, nx_q, cnt_q;
  logic [KEY_W-1:0] rd_key_q;
  logic [VAL_W-1:0] rd_val_q;
  logic [LW-1:0]    rd_prev_q, rd_next_q;

  logic             out_valid_q;
  res_status_e      out_status_q;
  logic [IW-1:0]    out_node_q;
  logic [LW-1:0]    out_prev_q, out_next_q;
  logic [KEY_W-1:0] out_key_q;
  logic [VAL_W-1:0] out_val_q;
  logic             out_last_q;

  logic [LW-1:0]    limit;
  logic             nx_valid, pv_valid, rd_next_valid;
  logic [LW-1:0]    nx_norm;
  logic [IW-1:0]    new_idx, done_idx;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             prev_we, next_we;
  logic [IW-1:0]    prev_waddr, next_waddr;
  logic [LW-1:0]    prev_wdata, next_wdata;
  logic [LW:0]      cnt_inc;

  assign limit         = (cap_q < NONE) ? cap_q : NONE;
  assign nx_valid      = (nx_q < NONE);
  assign pv_valid      = (pv_q < NONE);
  assign rd_next_valid = (rd_next_q < NONE);
  assign nx_norm       = nx_valid ? nx_q : NONE;
  assign new_idx       = used_q[IW-1:0];
  assign done_idx      = IW'(used_q - LW'(1));
  assign cnt_inc       = {1'b0, cnt_q} + (LW+1)'(1);

  assign status_o.is_walk    = (action_e'(in_action_i) == ACT_WALK);
  assign status_o.pool_full  = (used_q >= limit);
  assign status_o.list_empty = (used_q == '0) || (head_q >= NONE);
  assign status_o.scan_more  = nx_valid && (cnt_q < used_q) && (rd_key_q < key_q);
  assign status_o.walk_fin   = !rd_next_valid || (cnt_inc >= {1'b0, used_q});
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Read port: the head on start, otherwise the successor just read.
  assign rd_en   = cmd_i.start_ins || cmd_i.start_walk || cmd_i.scan_step || cmd_i.walk_step;
  assign rd_addr = (cmd_i.start_ins || cmd_i.start_walk) ? head_q[IW-1:0] : rd_next_q[IW-1:0];

  // Link writes: the new node first, then its neighbours in the next cycle.
  // The node count is still that of the new node while the neighbours are patched.
  assign prev_we    = cmd_i.link_node || (cmd_i.fix_links && nx_valid);
  assign prev_waddr = cmd_i.link_node ? new_idx : nx_q[IW-1:0];
  assign prev_wdata = cmd_i.link_node ? pv_q : {1'b0, new_idx};
  assign next_we    = cmd_i.link_node || (cmd_i.fix_links && pv_valid);
  assign next_waddr = cmd_i.link_node ? new_idx : pv_q[IW-1:0];
  assign next_wdata = cmd_i.link_node ? nx_norm : {1'b0, new_idx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_node) begin
      key_mem[new_idx] <= key_q;
      val_mem[new_idx] <= val_q;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (rd_en) begin
      rd_key_q  <= key_mem[rd_addr];
      rd_val_q  <= val_mem[rd_addr];
      rd_prev_q <= prev_mem[rd_addr];
      rd_next_q <= next_mem[rd_addr];
    end
  end

  // Search and walk pointers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_ins) begin
      key_q <= in_data_i[KEY_W-1:0];
      val_q <= in_data_i[KEY_W+VAL_W-1:KEY_W];
    end
    if (cmd_i.start_ins || cmd_i.start_walk) begin
      pv_q  <= NONE;
      nx_q  <= head_q;
      cnt_q <= '0;
    end else if (cmd_i.scan_step) begin
      pv_q  <= nx_q;
      nx_q  <= rd_next_q;
      cnt_q <= cnt_inc[LW-1:0];
    end else if (cmd_i.walk_step) begin
      nx_q  <= rd_next_q;
      cnt_q <= cnt_inc[LW-1:0];
    end else if (cmd_i.link_node) begin
      nx_q  <= nx_norm;
    end
  end

  // List registers and the capacity register. A pool smaller than 64 nodes
  // starts with its whole size in force.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= (NODES < 64) ? NONE : LW'(64);
      head_q <= NONE;
      used_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.fix_links) begin
        used_q <= used_q + LW'(1);
        if (!pv_valid) begin
          head_q <= {1'b0, new_idx};
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.out_kind;
      case (cmd_i.out_kind)
        RES_INSERTED: begin
          out_node_q <= done_idx;
          out_prev_q <= pv_q;
          out_next_q <= nx_q;
          out_key_q  <= '0;
          out_val_q  <= '0;
          out_last_q <= 1'b1;
        end
        RES_ENTRY: begin
          out_node_q <= nx_q[IW-1:0];
          out_prev_q <= rd_prev_q;
          out_next_q <= rd_next_q;
          out_key_q  <= rd_key_q;
          out_val_q  <= rd_val_q;
          out_last_q <= status_o.walk_fin;
        end
        default: begin
          out_node_q <= '0;
          out_prev_q <= NONE;
          out_next_q <= NONE;
          out_key_q  <= '0;
          out_val_q  <= '0;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_node_o   = out_node_q;
  assign out_prev_o   = out_prev_q;
  assign out_next_o   = out_next_q;
  assign out_key_o    = out_key_q;
  assign out_value_o  = out_val_q;
  assign out_last_o   = out_last_q;

  // The node count never goes beyond the pool.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= NONE)
    else $error("node count beyond the pool");

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // A new node is only written while a free node remains.
  a_link_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.link_node |-> (used_q < limit))
    else $error("node written into a full pool");

  // Patching the links counts exactly one node.
  a_fix_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fix_links |=> (used_q == $past(used_q) + LW'(1)))
    else $error("node count not advanced by one");

endmodule

/* design/sorted_linked_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// Sorted linked list engine
// Key-ordered doubly linked list in a fixed node pool, with insert and walk.
// ----------------------------------------------------------------------------
//
// Channel      | Direction | Beat contents
// -------------+-----------+-------------------------------------------------
// s_axis       | in        | tuser: action; tdata: item_key, item_value
// m_axis       | out       | tuser: status; tdata: node, prev, next, key,
//              |           | value; tlast: final result of the item
// cfg          | in        | capacity, written whenever cfg_we_i is high
//
// An insert searches from the head, then writes the new node, patches its
// neighbours and loads its result; the search follows one link per cycle
// through the registered read port of the node memories.
// A walk reads the head and then hands out its entries in list order.
// A full pool or an empty list is answered from its own state, with no search.
// Reset clears the list (no head, no nodes) and sets capacity to min(NODES, 64);
// the node memories need no clearing pass. A stalled output holds the engine in
// place, and one new item may be taken while the last result waits.
// ----------------------------------------------------------------------------
module sorted_linked_list_engine_unit #(
  parameter int unsigned NODES = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration: capacity.
  input  logic                                   cfg_we_i,
  input  logic [$clog2(NODES):0]                 cfg_wdata_i,
  // Input items.
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: item_key [63:0], item_value [127:64]
  input  logic [slle_pkg::KEY_W+slle_pkg::VAL_W-1:0] s_axis_tdata_i,
  // tuser: action [0]
  input  logic                                   s_axis_tuser_i,
  // Result items.
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // tdata: node_index, prev_index, next_index, out_key, out_value, zero pad
  output logic [((3*$clog2(NODES)+2+slle_pkg::KEY_W+slle_pkg::VAL_W+7)/8)*8-1:0]
                                                 m_axis_tdata_o,
  // tuser: status [1:0]
  output logic [1:0]                             m_axis_tuser_o,
  output logic                                   m_axis_tlast_o
);
  import slle_pkg::*;

  localparam int unsigned IW     = $clog2(NODES);
  localparam int unsigned LW     = IW + 1;
  localparam int unsigned PAY_W  = IW + 2 * LW + KEY_W + VAL_W;
  localparam int unsigned DATA_W = ((PAY_W + 7) / 8) * 8;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [IW-1:0]    out_node;
  logic [LW-1:0]    out_prev, out_next;
  logic [KEY_W-1:0] out_key;
  logic [VAL_W-1:0] out_value;

  slle_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  slle_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_data_i    (s_axis_tdata_i),
    .in_action_i  (s_axis_tuser_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_node_o   (out_node),
    .out_prev_o   (out_prev),
    .out_next_o   (out_next),
    .out_key_o    (out_key),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast_o)
  );

  // Fields packed from the lowest bit up, zero padding at the top.
  assign m_axis_tdata_o = DATA_W'({out_value, out_key, out_next, out_prev, out_node});

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted linked list engine testbench
// Drives insert and walk beats through the input stream, keeps a mirror of the
// ordered node pool and checks every result beat field by field against it.
// ----------------------------------------------------------------------------
module testbench;
  import slle_pkg::*;

  localparam int NODES       = 64;
  localparam int IDX_W       = $clog2(NODES);
  localparam int RES_DATA_W  = ((3 * IDX_W + 2 + KEY_W + VAL_W + 7) / 8) * 8;
  localparam logic [6:0] NO_NODE = 7'(NODES);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD_CYCLES = 400;

  // Offsets of the result fields in the master tdata, lowest first.
  localparam int NODE_LSB  = 0;
  localparam int PREV_LSB  = NODE_LSB + IDX_W;
  localparam int NEXT_LSB  = PREV_LSB + IDX_W + 1;
  localparam int KEY_LSB   = NEXT_LSB + IDX_W + 1;
  localparam int VALUE_LSB = KEY_LSB + KEY_W;

  typedef struct packed {
    res_status_e      status;
    logic [IDX_W-1:0] node;
    logic [IDX_W:0]   prev_node;
    logic [IDX_W:0]   next_node;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             last;
  } list_result_t;

  // Mirror of the node pool; works out the result beats of each accepted item.
  class list_mirror;
    logic [KEY_W-1:0] keys[NODES];
    logic [VAL_W-1:0] values[NODES];
    logic [IDX_W:0]   prev_of[NODES];
    logic [IDX_W:0]   next_of[NODES];
    logic [IDX_W:0]   head;
    int unsigned      used;
    int unsigned      capacity;
    list_result_t     pending_results[$];
    int unsigned      errors;
    int unsigned      inserts, full_answers, walked_entries, empty_walks;

    function new();
      head = NO_NODE;
      used = 0;
      capacity = 64;
      errors = 0;
      inserts = 0;
      full_answers = 0;
      walked_entries = 0;
      empty_walks = 0;
    endfunction

    function void push_result(res_status_e st, int unsigned node, logic [IDX_W:0] pv,
                              logic [IDX_W:0] nx, logic [KEY_W-1:0] k,
                              logic [VAL_W-1:0] v, logic lst);
      list_result_t r;
      r.status = st;
      r.node = IDX_W'(node);
      r.prev_node = pv;
      r.next_node = nx;
      r.key = k;
      r.value = v;
      r.last = lst;
      pending_results.push_back(r);
    endfunction

    function void note_item(action_e act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int unsigned limit, n, steps, count;
      logic [IDX_W:0] pv, nx, cur;
      logic fin;
      if (act == ACT_INSERT) begin
        limit = (capacity < NODES) ? capacity : NODES;
        if (used >= limit) begin
          full_answers++;
          push_result(RES_FULL, 0, NO_NODE, NO_NODE, '0, '0, 1'b1);
        end else begin
          n = used;
          pv = NO_NODE;
          nx = head;
          steps = 0;
          // Stop at the first node whose key is not below the new one.
          while (nx < NO_NODE && steps < used && keys[nx[IDX_W-1:0]] < k) begin
            pv = nx;
            nx = next_of[nx[IDX_W-1:0]];
            steps++;
          end
          if (nx >= NO_NODE) nx = NO_NODE;
          keys[n] = k;
          values[n] = v;
          prev_of[n] = pv;
          next_of[n] = nx;
          if (nx != NO_NODE) prev_of[nx[IDX_W-1:0]] = (IDX_W + 1)'(n);
          if (pv != NO_NODE) next_of[pv[IDX_W-1:0]] = (IDX_W + 1)'(n);
          else head = (IDX_W + 1)'(n);
          used = n + 1;
          inserts++;
          push_result(RES_INSERTED, n, pv, nx, '0, '0, 1'b1);
        end
      end else if (used == 0 || head >= NO_NODE) begin
        empty_walks++;
        push_result(RES_EMPTY, 0, NO_NODE, NO_NODE, '0, '0, 1'b1);
      end else begin
        cur = head;
        count = 0;
        fin = 1'b0;
        while (!fin && cur < NO_NODE && count < used) begin
          nx = next_of[cur[IDX_W-1:0]];
          fin = !(nx < NO_NODE) || (count + 1 >= used);
          push_result(RES_ENTRY, cur, prev_of[cur[IDX_W-1:0]], nx,
                      keys[cur[IDX_W-1:0]], values[cur[IDX_W-1:0]], fin);
          walked_entries++;
          count++;
          cur = nx;
        end
      end
    endfunction

    function void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting: status %0d node %0d",
               got.status, got.node);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("node_index", 64'(want.node), 64'(got.node));
        check_field("prev_index", 64'(want.prev_node), 64'(got.prev_node));
        check_field("next_index", 64'(want.next_node), 64'(got.next_node));
        check_field("out_key", want.key, got.key);
        check_field("out_value", want.value, got.value);
        check_field("last", 64'(want.last), 64'(got.last));
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [IDX_W:0]         cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready_o;
  logic [KEY_W+VAL_W-1:0] s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_tready = 1'b0;
  logic [RES_DATA_W-1:0]  m_axis_tdata_o;
  logic [1:0]             m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  // Idling controls, changed by the stimulus between phases.
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  bit long_hold_req = 1'b0;
  int unsigned cycles = 0;

  list_mirror pool_mirror = new();

  sorted_linked_list_engine_unit #(
    .NODES(NODES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one item, after a random gap while sender_idle is set, and notes it once the beat is taken.
  // The valid is only lowered when a gap follows, so that back-to-back beats
  // never see a low and a high assigned in the same time step.
  task automatic send_item(input action_e act, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {v, k};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pool_mirror.note_item(act, k, v);
  endtask

  // Stops offering and waits until every expected result beat has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pool_mirror.pending_results.size() != 0);
  endtask

  // The capacity is only changed while the engine is idle.
  task automatic write_capacity(input int unsigned value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= (IDX_W + 1)'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    pool_mirror.capacity = value;
  endtask

  task automatic run_random_phase(input int unsigned cap, input int unsigned count,
                                  input bit idle);
    action_e act;
    logic [KEY_W-1:0] k;
    write_capacity(cap);
    sender_idle = idle;
    receiver_idle = idle;
    repeat (count) begin
      act = ($urandom_range(0, 4) == 0) ? ACT_WALK : ACT_INSERT;
      // A narrow key range makes equal keys common, so that ties get exercised.
      case ($urandom_range(0, 3))
        0:       k = KEY_W'($urandom_range(0, 7));
        1, 2:    k = {$urandom, $urandom};
        default: k = ($urandom_range(0, 1) != 0) ? '1 : '0;
      endcase
      send_item(act, k, {$urandom, $urandom});
    end
  endtask

  // Receiving side: random stalls before each beat while receiver_idle is set, and one long
  // hold-off on request so that the engine backs up and refuses further input.
  initial begin
    int unsigned stall;
    list_result_t got;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = receiver_idle ? $urandom_range(0, 14) : 0;
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.status    = res_status_e'(m_axis_tuser_o);
      got.node      = m_axis_tdata_o[NODE_LSB +: IDX_W];
      got.prev_node = m_axis_tdata_o[PREV_LSB +: IDX_W + 1];
      got.next_node = m_axis_tdata_o[NEXT_LSB +: IDX_W + 1];
      got.key       = m_axis_tdata_o[KEY_LSB +: KEY_W];
      got.value     = m_axis_tdata_o[VALUE_LSB +: VAL_W];
      got.last      = m_axis_tlast_o;
      pool_mirror.check_result(got);
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty walk, a zero capacity, keys at both extremes,
    // equal keys, a full pool, a capacity below use and the top capacity.
    send_item(ACT_WALK, '1, '1);
    write_capacity(0);
    send_item(ACT_INSERT, 64'd5, 64'd9);
    send_item(ACT_WALK, '0, '0);
    write_capacity(3);
    send_item(ACT_INSERT, '1, '0);
    send_item(ACT_INSERT, '0, '1);
    send_item(ACT_INSERT, '1, 64'h5555_5555_5555_5555);
    send_item(ACT_INSERT, 64'h8000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(ACT_WALK, '1, '1);
    write_capacity(1);
    send_item(ACT_INSERT, 64'd1, 64'd1);
    send_item(ACT_WALK, '0, '0);
    write_capacity(127);
    send_item(ACT_INSERT, '0, 64'h0123_4567_89ab_cdef);
    send_item(ACT_INSERT, 64'h7fff_ffff_ffff_ffff, 64'hfedc_ba98_7654_3210);
    send_item(ACT_INSERT, 64'h8000_0000_0000_0000, '1);
    send_item(ACT_WALK, '1, '0);

    // Random part in three settings; the long hold-off is requested once the
    // first phase has drained, so that it falls in the phase without idling
    // while the sender keeps offering beats throughout.
    run_random_phase($urandom_range(10, 30), 50, 1'b1);
    drain_results();
    long_hold_req = 1'b1;
    run_random_phase(64, 40, 1'b0);
    run_random_phase(127, 63, 1'b1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d inserts, %0d full-pool answers, %0d walked entries and %0d empty walks",
             pool_mirror.inserts, pool_mirror.full_answers,
             pool_mirror.walked_entries, pool_mirror.empty_walks);
    $display("in %0d cycles, with capacities from zero up to the register maximum.", cycles);
    if (pool_mirror.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
